### sv/ipv4fr_pkg.sv
package ipv4fr_pkg;

  // Stream widths
  localparam int InWidth  = 176;
  localparam int OutWidth = 64;

  // Bucket store
  localparam int BucketBits = 8;
  localparam int Buckets    = 1 << BucketBits;

  // Header constants
  localparam int           MfBitPos = 13;
  localparam logic [7:0]   UdpProto = 8'd17;
  localparam logic [7:0]   HashSeed = 8'h1D;

  // Result status codes
  typedef enum logic [2:0] {
    ST_LEN_ERR  = 3'd0,
    ST_CSUM_ERR = 3'd1,
    ST_WHOLE    = 3'd2,
    ST_REJECT   = 3'd3,
    ST_ACCEPT   = 3'd4,
    ST_REASM    = 3'd5
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SUM  = 2'd1,
    S_EVAL = 2'd2
  } state_e;

  // One received header, last field in the lowest bits
  typedef struct packed {
    logic [31:0] destination_address;
    logic [31:0] source_address;
    logic [15:0] header_checksum;
    logic [7:0]  protocol_number;
    logic [7:0]  time_to_live;
    logic [15:0] flags_fragment;
    logic [15:0] ident;
    logic [15:0] total_length;
    logic [7:0]  type_of_service;
    logic [7:0]  version_ihl;
    logic [15:0] frame_length;
  } in_item_t;

  // One result, last field in the lowest bits
  typedef struct packed {
    logic        expected_dropped;
    logic        deliver_udp;
    logic [15:0] datagram_length;
    logic        more_fragments;
    logic [15:0] fragment_offset;
    logic [15:0] payload_length;
    logic [7:0]  bucket;
    status_e     status;
  } out_item_t;

  // One bucket entry
  typedef struct packed {
    logic [15:0] received_sum;
    logic [15:0] expected_total;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic stage;
    logic commit;
  } dp_cmd_t;

endpackage

### sv/ipv4fr_ctrl.sv
module ipv4fr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ipv4fr_pkg::dp_cmd_t cmd_o
);
  import ipv4fr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Hold state and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence one request: capture, sum and read, evaluate and write
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load_item = in_fire;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.stage = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Track the result register
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  a_fire_to_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_SUM)
    else $error("accepted request did not enter the sum step");

  a_fire_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ##1 state_q == S_EVAL)
    else $error("request did not reach evaluation two cycles after accept");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.commit)
    else $error("pending result overwritten");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q && state_q == S_IDLE)
    else $error("committed result not presented");

endmodule

### sv/ipv4fr_datapath.sv
module ipv4fr_datapath #(
  parameter int LENGTH_LIMIT = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ipv4fr_pkg::dp_cmd_t   cmd_i,
  input  ipv4fr_pkg::in_item_t  item_i,
  output ipv4fr_pkg::out_item_t result_o
);
  import ipv4fr_pkg::*;

  localparam logic [16:0] LimitW = 17'(LENGTH_LIMIT);

  in_item_t item_q;

  // Stage registers after the sum step
  logic                  len_err_q;
  logic [19:0]           csum_raw_q;
  logic [15:0]           rx_chk_q;
  logic                  frag_q;
  logic                  range_err_q;
  logic [BucketBits-1:0] bucket_q;
  logic [15:0]           payload_q;
  logic [15:0]           offset_q;
  logic                  more_q;
  logic                  udp_q;

  // Bucket memory with per-entry valid bits
  entry_t              mem [Buckets];
  logic [Buckets-1:0]  valid_q;
  entry_t              rd_q;
  logic                rd_vld_q;

  out_item_t out_q, out_d;

  // Sum step signals
  logic [5:0]            header_bytes;
  logic [BucketBits-1:0] bucket_d;
  logic [19:0]           csum_raw_d;
  logic [16:0]           span;
  logic [15:0]           offset_d;
  logic [15:0]           payload_d;

  // Evaluate step signals
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        csum_bad;
  entry_t      cur;
  logic [15:0] new_sum;
  logic [15:0] exp_kept;
  logic [15:0] exp_new;
  logic        dropped;
  logic        complete;
  logic        wr_en;
  entry_t      wr_data;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
  end

  // Length checks, raw checksum sum, hash
  always_comb begin
    header_bytes = {item_q.version_ihl[3:0], 2'b00};
    offset_d     = {item_q.flags_fragment[12:0], 3'b000};
    payload_d    = item_q.total_length - 16'(header_bytes);
    span         = 17'(payload_d) + 17'(offset_d);
    csum_raw_d   = 20'({item_q.version_ihl, item_q.type_of_service})
                 + 20'(item_q.total_length)
                 + 20'(item_q.ident)
                 + 20'(item_q.flags_fragment)
                 + 20'({item_q.time_to_live, item_q.protocol_number})
                 + 20'(item_q.source_address[31:16])
                 + 20'(item_q.source_address[15:0])
                 + 20'(item_q.destination_address[31:16])
                 + 20'(item_q.destination_address[15:0]);
    bucket_d     = HashSeed
                 ^ item_q.source_address[31:24] ^ item_q.source_address[23:16]
                 ^ item_q.source_address[15:8]  ^ item_q.source_address[7:0]
                 ^ item_q.destination_address[31:24]
                 ^ item_q.destination_address[23:16]
                 ^ item_q.destination_address[15:8]
                 ^ item_q.destination_address[7:0]
                 ^ item_q.ident[15:8] ^ item_q.ident[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage) begin
      len_err_q   <= (item_q.frame_length != item_q.total_length)
                  || (16'(header_bytes) > item_q.total_length);
      csum_raw_q  <= csum_raw_d;
      rx_chk_q    <= item_q.header_checksum;
      frag_q      <= item_q.flags_fragment[MfBitPos] || (offset_d != '0);
      range_err_q <= span >= LimitW;
      bucket_q    <= bucket_d;
      payload_q   <= payload_d;
      offset_q    <= offset_d;
      more_q      <= item_q.flags_fragment[MfBitPos];
      udp_q       <= item_q.protocol_number == UdpProto;
    end
  end

  // Read the bucket entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.stage) rd_q <= mem[bucket_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (cmd_i.stage) begin
      rd_vld_q <= valid_q[bucket_d];
    end
  end

  // Fold checksum, update the bucket, form the result
  always_comb begin
    fold1    = 17'(csum_raw_q[15:0]) + 17'(csum_raw_q[19:16]);
    fold2    = fold1[15:0] + 16'(fold1[16]);
    csum_bad = (~fold2) != rx_chk_q;
    cur      = rd_vld_q ? rd_q : '0;
    new_sum  = cur.received_sum + payload_q;
    dropped  = (cur.expected_total != '0) && (offset_q > cur.expected_total);
    exp_kept = dropped ? '0 : cur.expected_total;
    exp_new  = more_q ? exp_kept : (offset_q + payload_q);
    complete = new_sum == exp_new;
    wr_en    = 1'b0;
    wr_data  = complete ? '0 : {new_sum, exp_new};
    out_d    = '0;
    if (len_err_q) begin
      out_d.status = ST_LEN_ERR;
    end else if (csum_bad) begin
      out_d.status = ST_CSUM_ERR;
    end else begin
      out_d.payload_length  = payload_q;
      out_d.fragment_offset = offset_q;
      out_d.more_fragments  = more_q;
      if (!frag_q) begin
        out_d.status          = ST_WHOLE;
        out_d.datagram_length = payload_q;
        out_d.deliver_udp     = udp_q;
      end else begin
        out_d.bucket = bucket_q;
        if (range_err_q) begin
          out_d.status = ST_REJECT;
        end else begin
          wr_en                  = cmd_i.commit;
          out_d.expected_dropped = dropped;
          if (complete) begin
            out_d.status          = ST_REASM;
            out_d.datagram_length = exp_new;
            out_d.deliver_udp     = udp_q;
          end else begin
            out_d.status = ST_ACCEPT;
          end
        end
      end
    end
  end

  // Write back the bucket entry
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[bucket_q] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[bucket_q] <= 1'b1;
    end
  end

  // Hold the result for the output side
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= out_d;
  end

  assign result_o = out_q;

endmodule

### sv/ipv4_fragment_reassembly_tracker.sv
// IPv4 fragment reassembly tracker.
// Input stream (s_axis_*): one received IPv4 header per request, with the
// length of the frame that carried it. Output stream (m_axis_*): one status
// result per request, in order.
// Each request is checked for length and 20-byte header checksum; whole
// packets are reported directly, fragments are hashed to one of 256 buckets
// that keep a wrapping byte sum and the expected datagram total.
// A request passes a bucket read step and then an evaluate-and-write step on
// the single bucket memory, and no new request is taken in between.
// A new request is taken as soon as the previous one has been written to the
// result register, even while that result still waits for m_axis_tready.
// If the receiver stalls, the next request waits in evaluation until the
// result register is free, and input acceptance stops.
// Reset clears all bucket valid bits at once, so every bucket reads as empty
// right after reset with no clearing pass; the result register is emptied.
module ipv4_fragment_reassembly_tracker #(
  parameter int LENGTH_LIMIT = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // frame_length, version_ihl, type_of_service, total_length, ident,
  // flags_fragment, time_to_live, protocol_number, header_checksum,
  // source_address, destination_address
  input  logic [ipv4fr_pkg::InWidth-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status, bucket, payload_length, fragment_offset, more_fragments,
  // datagram_length, deliver_udp, expected_dropped, zero fill
  output logic [ipv4fr_pkg::OutWidth-1:0]  m_axis_tdata
);
  import ipv4fr_pkg::*;

  dp_cmd_t   cmd;
  out_item_t result;

  ipv4fr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ipv4fr_datapath #(
    .LENGTH_LIMIT (LENGTH_LIMIT)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (in_item_t'(s_axis_tdata)),
    .result_o (result)
  );

  assign m_axis_tdata = OutWidth'(result);

endmodule

### verif/ipv4_fragment_reassembly_tracker_test.sv
`timescale 1ns / 100ps

module ipv4_fragment_reassembly_tracker_test;
  import ipv4fr_pkg::*;

  localparam int          LengthLimit = 65536;
  localparam int          CycleLimit  = 400000;
  localparam int          ResultBits  = $bits(out_item_t);
  localparam logic [15:0] MoreFrags   = 16'(1 << MfBitPos);
  localparam logic [15:0] OffsetMask  = 16'h1fff;
  localparam logic [7:0]  VerIhl5     = 8'h45;

  // One pending request with the idling that applies while it is sent
  typedef struct {
    in_item_t hdr;
    bit       drain;
    int       gap_pct;
    int       stall_pct;
  } request_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;

  request_t   pending[$];
  out_item_t  results_due[$];
  logic [15:0] bucket_sum   [Buckets] = '{default: '0};
  logic [15:0] bucket_total [Buckets] = '{default: '0};

  bit  req_taken = 1'b0;
  bit  pause_next = 1'b0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  ready_stall_pct = 0;
  int  requests_queued = 0;
  int  errors = 0;
  int  cycle_count = 0;

  ipv4_fragment_reassembly_tracker #(
    .LENGTH_LIMIT(LengthLimit)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ones-complement checksum over the fixed 20-byte header, checksum word as zero
  function automatic logic [15:0] header_sum(in_item_t h);
    logic [31:0] acc;
    acc = {h.version_ihl, h.type_of_service} + h.total_length + h.ident
        + h.flags_fragment + {h.time_to_live, h.protocol_number}
        + h.source_address[31:16] + h.source_address[15:0]
        + h.destination_address[31:16] + h.destination_address[15:0];
    acc = acc[15:0] + acc[31:16];
    acc = acc[15:0] + acc[31:16];
    return ~acc[15:0];
  endfunction

  function automatic logic [7:0] byte_fold(logic [31:0] v);
    return v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
  endfunction

  // Work out the status of one header and update the bucket it maps to
  function automatic out_item_t track_header(in_item_t h);
    out_item_t   r;
    logic [5:0]  hdr_bytes;
    logic [15:0] offset;
    logic [15:0] payload;
    logic [7:0]  b;
    bit          more;
    r = '0;
    r.status = ST_LEN_ERR;
    hdr_bytes = {h.version_ihl[3:0], 2'b00};
    if (h.frame_length != h.total_length || 16'(hdr_bytes) > h.total_length) begin
      return r;
    end
    if (header_sum(h) != h.header_checksum) begin
      r.status = ST_CSUM_ERR;
      return r;
    end
    more    = h.flags_fragment[MfBitPos];
    offset  = {h.flags_fragment[12:0], 3'b000};
    payload = h.total_length - 16'(hdr_bytes);
    r.payload_length  = payload;
    r.fragment_offset = offset;
    r.more_fragments  = more;
    if (!more && offset == 16'd0) begin
      r.status          = ST_WHOLE;
      r.datagram_length = payload;
      r.deliver_udp     = (h.protocol_number == UdpProto);
      return r;
    end
    b = HashSeed ^ byte_fold(h.source_address) ^ byte_fold(h.destination_address)
      ^ h.ident[15:8] ^ h.ident[7:0];
    r.bucket = b;
    if (int'(payload) + int'(offset) >= LengthLimit) begin
      r.status = ST_REJECT;
      return r;
    end
    bucket_sum[b] = bucket_sum[b] + payload;
    // Drop a stale expected total that this offset already exceeds
    if (bucket_total[b] != 16'd0 && offset > bucket_total[b]) begin
      bucket_total[b]    = 16'd0;
      r.expected_dropped = 1'b1;
    end
    if (!more) begin
      bucket_total[b] = offset + payload;
    end
    if (bucket_sum[b] == bucket_total[b]) begin
      r.status          = ST_REASM;
      r.datagram_length = bucket_total[b];
      r.deliver_udp     = (h.protocol_number == UdpProto);
      bucket_sum[b]     = 16'd0;
      bucket_total[b]   = 16'd0;
    end else begin
      r.status = ST_ACCEPT;
    end
    return r;
  endfunction

  function automatic in_item_t make_header(logic [31:0] src, logic [31:0] dst,
                                           logic [15:0] id, logic [7:0] ver_ihl,
                                           int payload, logic [15:0] flags,
                                           logic [7:0] proto);
    in_item_t h;
    h.version_ihl         = ver_ihl;
    h.type_of_service     = 8'($urandom);
    h.total_length        = 16'(4 * ver_ihl[3:0] + payload);
    h.frame_length        = h.total_length;
    h.ident               = id;
    h.flags_fragment      = flags;
    h.time_to_live        = 8'($urandom);
    h.protocol_number     = proto;
    h.source_address      = src;
    h.destination_address = dst;
    h.header_checksum     = header_sum(h);
    return h;
  endfunction

  task automatic queue_request(in_item_t h);
    pending.push_back('{hdr: h, drain: pause_next, gap_pct: send_idle_pct,
                        stall_pct: recv_stall_pct});
    pause_next = 1'b0;
    requests_queued++;
  endtask

  // Queue the fragments of one datagram, sometimes reordered, lost or repeated
  task automatic send_datagram();
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] id;
    logic [15:0] flags;
    logic [7:0]  proto;
    logic [7:0]  ver;
    int          n, cum, skip, dup, tmp, a, b, i, k;
    int          len[4];
    int          off[4];
    int          order[4];
    src   = $urandom;
    dst   = $urandom;
    id    = 16'($urandom);
    proto = ($urandom_range(1) != 0) ? UdpProto : 8'($urandom);
    n     = $urandom_range(1, 4);
    cum   = 0;
    for (i = 0; i < n - 1; i++) begin
      off[i] = cum;
      len[i] = ($urandom_range(15) == 0) ? 8 * $urandom_range(1, 2400)
                                         : 8 * $urandom_range(0, 24);
      cum += len[i];
    end
    off[n-1] = cum;
    len[n-1] = $urandom_range(0, 60);
    if (n == 1 && $urandom_range(15) == 0) begin
      len[0] = $urandom_range(0, 65475);
    end
    for (i = 0; i < 4; i++) begin
      order[i] = i;
    end
    if ($urandom_range(9) < 4) begin
      repeat (2) begin
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
        tmp = order[a];
        order[a] = order[b];
        order[b] = tmp;
      end
    end
    skip = (n > 1 && $urandom_range(9) == 0) ? $urandom_range(n - 1) : -1;
    dup  = ($urandom_range(19) == 0) ? $urandom_range(n - 1) : -1;
    for (i = 0; i < n; i++) begin
      k = order[i];
      if (k != skip) begin
        ver = ($urandom_range(4) == 0) ? {4'($urandom), 4'($urandom_range(5, 15))} : VerIhl5;
        flags = (16'(off[k] / 8) & OffsetMask) | ((k < n - 1) ? MoreFrags : 16'h0000)
              | 16'($urandom_range(3) << 14);
        queue_request(make_header(src, dst, id, ver, len[k], flags, proto));
        if (k == dup) begin
          queue_request(make_header(src, dst, id, ver, len[k], flags, proto));
        end
      end
    end
  endtask

  // Queue one malformed, corrupted or out-of-range request
  task automatic send_noise();
    in_item_t h;
    int       kind;
    kind = $urandom_range(4);
    h = make_header($urandom, $urandom, 16'($urandom), VerIhl5, $urandom_range(0, 1480),
                    16'($urandom_range(3) << 14), 8'($urandom));
    case (kind)
      0: h.header_checksum ^= 16'(1 << $urandom_range(15));
      1: h.frame_length ^= 16'($urandom_range(1, 65535));
      2: begin
        h.version_ihl[3:0] = 4'($urandom_range(1, 15));
        h.total_length     = 16'($urandom_range(0, 4 * h.version_ihl[3:0] - 1));
        h.frame_length     = h.total_length;
        h.header_checksum  = header_sum(h);
      end
      3: begin
        h = in_item_t'(176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(1) != 0) begin
          h.frame_length = h.total_length;
        end
        if ($urandom_range(3) == 0) begin
          h.header_checksum = header_sum(h);
        end
      end
      default: begin
        h = make_header($urandom, $urandom, 16'($urandom), VerIhl5, $urandom_range(0, 8000),
                        16'($urandom_range(7000, 8191))
                        | (($urandom_range(1) != 0) ? MoreFrags : 16'h0000),
                        8'($urandom));
      end
    endcase
    queue_request(h);
  endtask

  // Present requests at the falling edge, with random gaps and ready stalls
  always @(negedge clk_i) begin
    request_t next_req;
    bit       send;
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        send = 1'b0;
        if (pending.size() != 0) begin
          if (pending[0].drain && results_due.size() == 0) begin
            pending[0].drain = 1'b0;
          end
          send = !pending[0].drain && ($urandom_range(99) >= pending[0].gap_pct);
        end
        if (send) begin
          next_req = pending.pop_front();
          s_axis_tdata <= next_req.hdr;
          ready_stall_pct = next_req.stall_pct;
        end
        s_axis_tvalid <= send;
      end
      m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_item_t'(m_axis_tdata[ResultBits-1:0]);
        if (results_due.size() == 0) begin
          $error("result with nothing pending: %h", m_axis_tdata);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, got.status);
          check_field("bucket", want.bucket, got.bucket);
          check_field("payload_length", want.payload_length, got.payload_length);
          check_field("fragment_offset", want.fragment_offset, got.fragment_offset);
          check_field("more_fragments", want.more_fragments, got.more_fragments);
          check_field("datagram_length", want.datagram_length, got.datagram_length);
          check_field("deliver_udp", want.deliver_udp, got.deliver_udp);
          check_field("expected_dropped", want.expected_dropped, got.expected_dropped);
          check_field("zero_fill", 0, m_axis_tdata[OutWidth-1:ResultBits]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(track_header(s_axis_tdata));
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_item_t h;
    int       p;
    int       target;
    int       phase_gap[4];
    int       phase_stall[4];
    phase_gap   = '{0, 73, 0, 32};
    phase_stall = '{0, 0, 73, 32};

    // Directed requests, no idling
    h = make_header(32'hFFFF_FFFF, 32'h0, 16'hFFFF, VerIhl5, 8, 16'h0000, UdpProto);
    h.frame_length ^= 16'h0001;
    queue_request(h);
    // header longer than the packet
    h = make_header(32'h0A00_0001, 32'h0A00_0002, 16'h0042, VerIhl5, 20, 16'h0000, 8'd6);
    h.version_ihl     = 8'h4F;
    h.header_checksum = header_sum(h);
    queue_request(h);
    h = make_header(32'hC0A8_0101, 32'hC0A8_0102, 16'h0001, VerIhl5, 12, 16'h0000, 8'd6);
    h.header_checksum ^= 16'h8000;
    queue_request(h);
    queue_request(make_header(32'h0, 32'h0, 16'h0, VerIhl5, 8, 16'h0000, UdpProto));
    queue_request(make_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, VerIhl5, 65515,
                              16'hC000, 8'd6));
    // zero header nibble, empty packet
    queue_request(make_header(32'h8000_0000, 32'h0000_0001, 16'h8000, 8'hF0, 0,
                              16'h0000, 8'hFF));
    // empty fragment completes at once
    queue_request(make_header(32'h1, 32'h2, 16'h3, VerIhl5, 0, MoreFrags, 8'd6));
    // offset at its top: one byte past the limit, then exactly inside it
    queue_request(make_header(32'h5, 32'h6, 16'h7, VerIhl5, 8, MoreFrags | OffsetMask, 8'd6));
    queue_request(make_header(32'h9, 32'hA, 16'hB, VerIhl5, 0, OffsetMask, UdpProto));
    // two fragments reassemble
    queue_request(make_header(32'h0A01_0203, 32'h0A04_0506, 16'h1234, VerIhl5, 16,
                              MoreFrags, UdpProto));
    queue_request(make_header(32'h0A01_0203, 32'h0A04_0506, 16'h1234, 8'h46, 10,
                              16'h0002, UdpProto));
    // stale expected total gets dropped, then the datagram completes
    queue_request(make_header(32'h0B00_0001, 32'h0B00_0002, 16'h0BAD, VerIhl5, 8,
                              16'h0001, 8'd6));
    queue_request(make_header(32'h0B00_0001, 32'h0B00_0002, 16'h0BAD, VerIhl5, 8,
                              MoreFrags | 16'h0003, 8'd6));
    queue_request(make_header(32'h0B00_0001, 32'h0B00_0002, 16'h0BAD, VerIhl5, 0,
                              16'h0002, 8'd6));
    // byte sum wraps, so the last fragment does not complete the datagram
    pause_next = 1'b1;
    queue_request(make_header(32'h0C00_0001, 32'h0C00_0002, 16'hBEEF, VerIhl5, 40000,
                              MoreFrags, UdpProto));
    queue_request(make_header(32'h0C00_0001, 32'h0C00_0002, 16'hBEEF, VerIhl5, 40000,
                              MoreFrags, UdpProto));
    queue_request(make_header(32'h0C00_0001, 32'h0C00_0002, 16'hBEEF, VerIhl5, 14456,
                              16'h0001, UdpProto));

    // Random requests over several idling phases, each opened by a full drain
    for (p = 0; p < 4; p++) begin
      send_idle_pct  = phase_gap[p];
      recv_stall_pct = phase_stall[p];
      pause_next     = 1'b1;
      target         = requests_queued + 310;
      while (requests_queued < target) begin
        if ($urandom_range(99) < 75) begin
          send_datagram();
        end else begin
          send_noise();
        end
      end
    end

    // Hold reset, then release between edges
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || s_axis_tvalid || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    if (errors == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### ipv4_fragment_reassembly_tracker.f
sv/ipv4fr_pkg.sv
sv/ipv4fr_ctrl.sv
sv/ipv4fr_datapath.sv
sv/ipv4_fragment_reassembly_tracker.sv
verif/ipv4_fragment_reassembly_tracker_test.sv
